// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the camera follow dead-zone RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CFDZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cfdz assertion failed");
`define CFDZ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cfdz reset assertion failed");
`else
`define CFDZ_ASSERT(lbl, prop)
`define CFDZ_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/cfdz_pkg.sv =====
// Types and codes shared by the camera follow dead-zone modules.
package cfdz_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_VIEW_W = 3'd0,
    REG_HALF_VIEW_H = 3'd1,
    REG_PAD_X       = 3'd2,
    REG_PAD_Y       = 3'd3,
    REG_WORLD_MIN_X = 3'd4,
    REG_WORLD_MIN_Y = 3'd5,
    REG_WORLD_MAX_X = 3'd6,
    REG_WORLD_MAX_Y = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    REQ_POINT = 1'b0,
    REQ_SET   = 1'b1
  } req_e;

  // Box tracker control: fold a corner in, and whether it closes the box.
  typedef struct packed {
    logic upd;
    logic last;
  } box_ctl_t;

endpackage

// ===== rtl/core/cfdz_if.sv =====
// Channel interfaces: corner/set items in, view results out, register writes.
interface cfdz_point_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, req_type, point_x, point_y, last_point, input ready);
  modport sink   (input valid, req_type, point_x, point_y, last_point, output ready);
endinterface

interface cfdz_view_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic                  moved;

  modport source (output valid, center_x, center_y, moved, input ready);
  modport sink   (input valid, center_x, center_y, moved, output ready);
endinterface

interface cfdz_cfg_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [cfdz_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_BITS-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cfdz_box.sv =====
// Running bounding box of the corner points of the current box.
module cfdz_box #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfdz_pkg::box_ctl_t            ctl_i,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  output logic signed [COORD_BITS-1:0]  left_o,
  output logic signed [COORD_BITS-1:0]  right_o,
  output logic signed [COORD_BITS-1:0]  top_o,
  output logic signed [COORD_BITS-1:0]  bottom_o
);
  import cfdz_pkg::*;

  logic signed [COORD_BITS-1:0] left_q, right_q, top_q, bottom_q;
  logic                         first_q;

  // Edges including the current corner; the first corner seeds the box.
  always_comb begin
    if (first_q) begin
      left_o   = px_i;
      right_o  = px_i;
      top_o    = py_i;
      bottom_o = py_i;
    end else begin
      left_o   = (px_i < left_q)   ? px_i : left_q;
      right_o  = (px_i > right_q)  ? px_i : right_q;
      top_o    = (py_i < top_q)    ? py_i : top_q;
      bottom_o = (py_i > bottom_q) ? py_i : bottom_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      left_q   <= left_o;
      right_q  <= right_o;
      top_q    <= top_o;
      bottom_q <= bottom_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (ctl_i.upd) begin
      first_q <= ctl_i.last;
    end
  end

endmodule

// ===== rtl/core/cfdz_axis.sv =====
// One axis: dead-zone pull of the centre, world clamp and saturation.
module cfdz_axis #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] center_i,
  input  logic        [COORD_BITS-2:0] half_i,
  input  logic        [COORD_BITS-2:0] pad_i,
  input  logic signed [COORD_BITS-1:0] lo_i,
  input  logic signed [COORD_BITS-1:0] hi_i,
  input  logic signed [COORD_BITS-1:0] wmin_i,
  input  logic signed [COORD_BITS-1:0] wmax_i,
  output logic                         moved_o,
  output logic signed [COORD_BITS-1:0] center_o
);
  localparam int unsigned W = COORD_BITS + 4;

  logic signed [W-1:0] c_w, h_w, p_w, lo_w, hi_w, wmin_w, wmax_w;
  logic signed [W-1:0] near_lo, near_hi, n_pull, n_clmp;
  logic signed [W-1:0] lim_max, lim_min;
  logic                pull_lo, pull_hi;

  assign c_w    = {{(W-COORD_BITS){center_i[COORD_BITS-1]}}, center_i};
  assign h_w    = {{(W-COORD_BITS+1){1'b0}}, half_i};
  assign p_w    = {{(W-COORD_BITS+1){1'b0}}, pad_i};
  assign lo_w   = {{(W-COORD_BITS){lo_i[COORD_BITS-1]}}, lo_i};
  assign hi_w   = {{(W-COORD_BITS){hi_i[COORD_BITS-1]}}, hi_i};
  assign wmin_w = {{(W-COORD_BITS){wmin_i[COORD_BITS-1]}}, wmin_i};
  assign wmax_w = {{(W-COORD_BITS){wmax_i[COORD_BITS-1]}}, wmax_i};

  assign lim_max = {{(W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  assign lim_min = {{(W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  assign near_lo = lo_w - (c_w - h_w);
  assign near_hi = (c_w + h_w) - hi_w;
  assign pull_lo = p_w > near_lo;
  assign pull_hi = p_w > near_hi;
  assign moved_o = pull_lo | pull_hi;

  // Right/bottom pull overrides left/top; max clamp overrides min clamp.
  always_comb begin
    n_pull = c_w;
    if (pull_lo) begin
      n_pull = lo_w + h_w - p_w;
    end
    if (pull_hi) begin
      n_pull = hi_w - h_w + p_w;
    end
    n_clmp = n_pull;
    if (n_pull - h_w < wmin_w) begin
      n_clmp = wmin_w + h_w;
    end
    if (n_clmp + h_w > wmax_w) begin
      n_clmp = wmax_w - h_w;
    end
    if (n_clmp > lim_max) begin
      center_o = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (n_clmp < lim_min) begin
      center_o = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      center_o = n_clmp[COORD_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/camera_follow_dead_zone_core.sv =====
// Flow: an accepted item is held in the input register; a set item or the last
// corner of a box then has its result presented from the result register.
// Throughput: one item per cycle while no result waits on a stalled output; an
// item's box, dead-zone pull and clamp are combinational between the two registers.
// Reset: clears registers to 0, view centre to 0, opens a new box, empties
// both stages. Register writes are never stalled (ready held high).
`include "assert_macros.svh"

module camera_follow_dead_zone_core #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfdz_point_if.sink   pt_i,
  cfdz_view_if.source  view_o,
  cfdz_cfg_if.sink     cfg_i
);
  import cfdz_pkg::*;

  // Configuration registers
  logic        [COORD_BITS-2:0] half_w_q, half_h_q, pad_x_q, pad_y_q;
  logic signed [COORD_BITS-1:0] wmin_x_q, wmin_y_q, wmax_x_q, wmax_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= '0;
      half_h_q <= '0;
      pad_x_q  <= '0;
      pad_y_q  <= '0;
      wmin_x_q <= '0;
      wmin_y_q <= '0;
      wmax_x_q <= '0;
      wmax_y_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_HALF_VIEW_W: half_w_q <= cfg_i.data[COORD_BITS-2:0];
        REG_HALF_VIEW_H: half_h_q <= cfg_i.data[COORD_BITS-2:0];
        REG_PAD_X:       pad_x_q  <= cfg_i.data[COORD_BITS-2:0];
        REG_PAD_Y:       pad_y_q  <= cfg_i.data[COORD_BITS-2:0];
        REG_WORLD_MIN_X: wmin_x_q <= cfg_i.data;
        REG_WORLD_MIN_Y: wmin_y_q <= cfg_i.data;
        REG_WORLD_MAX_X: wmax_x_q <= cfg_i.data;
        REG_WORLD_MAX_Y: wmax_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                         s1_vld_q;
  req_e                         s1_req_q;
  logic signed [COORD_BITS-1:0] s1_px_q, s1_py_q;
  logic                         s1_last_q;

  // Result register
  logic                         out_vld_q;
  logic signed [COORD_BITS-1:0] out_cx_q, out_cy_q;
  logic                         out_moved_q;

  logic signed [COORD_BITS-1:0] ctr_x_q, ctr_y_q;

  logic     yields, adv, take;
  box_ctl_t box_ctl;

  assign yields      = (s1_req_q == REQ_SET) | s1_last_q;
  assign adv         = s1_vld_q & (~yields | ~out_vld_q | view_o.ready);
  assign pt_i.ready  = ~s1_vld_q | adv;
  assign take        = pt_i.valid & pt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (pt_i.ready) begin
      s1_vld_q <= pt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_req_q  <= req_e'(pt_i.req_type);
      s1_px_q   <= pt_i.point_x;
      s1_py_q   <= pt_i.point_y;
      s1_last_q <= pt_i.last_point;
    end
  end

  assign box_ctl.upd  = adv & (s1_req_q == REQ_POINT);
  assign box_ctl.last = s1_last_q;

  logic signed [COORD_BITS-1:0] bx_l, bx_r, bx_t, bx_b;

  cfdz_box #(.COORD_BITS(COORD_BITS)) u_box (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (box_ctl),
    .px_i     (s1_px_q),
    .py_i     (s1_py_q),
    .left_o   (bx_l),
    .right_o  (bx_r),
    .top_o    (bx_t),
    .bottom_o (bx_b)
  );

  logic                         mv_x, mv_y, mv;
  logic signed [COORD_BITS-1:0] new_x, new_y;

  cfdz_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .center_i (ctr_x_q),
    .half_i   (half_w_q),
    .pad_i    (pad_x_q),
    .lo_i     (bx_l),
    .hi_i     (bx_r),
    .wmin_i   (wmin_x_q),
    .wmax_i   (wmax_x_q),
    .moved_o  (mv_x),
    .center_o (new_x)
  );

  cfdz_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .center_i (ctr_y_q),
    .half_i   (half_h_q),
    .pad_i    (pad_y_q),
    .lo_i     (bx_t),
    .hi_i     (bx_b),
    .wmin_i   (wmin_y_q),
    .wmax_i   (wmax_y_q),
    .moved_o  (mv_y),
    .center_o (new_y)
  );

  // A pull on either axis clamps both axes.
  assign mv = mv_x | mv_y;

  logic signed [COORD_BITS-1:0] ctr_x_d, ctr_y_d;
  logic                         moved_d;

  always_comb begin
    ctr_x_d = ctr_x_q;
    ctr_y_d = ctr_y_q;
    moved_d = 1'b0;
    if (s1_req_q == REQ_SET) begin
      ctr_x_d = s1_px_q;
      ctr_y_d = s1_py_q;
    end else if (s1_last_q && mv) begin
      ctr_x_d = new_x;
      ctr_y_d = new_y;
      moved_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q <= '0;
      ctr_y_q <= '0;
    end else if (adv) begin
      ctr_x_q <= ctr_x_d;
      ctr_y_q <= ctr_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && yields) begin
      out_vld_q <= 1'b1;
    end else if (view_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && yields) begin
      out_cx_q    <= ctr_x_d;
      out_cy_q    <= ctr_y_d;
      out_moved_q <= moved_d;
    end
  end

  assign view_o.valid    = out_vld_q;
  assign view_o.center_x = out_cx_q;
  assign view_o.center_y = out_cy_q;
  assign view_o.moved    = out_moved_q;

  `CFDZ_ASSERT(a_set_gives_unmoved, adv && s1_req_q == REQ_SET |=> out_vld_q && !out_moved_q)
  `CFDZ_ASSERT(a_mid_point_silent, adv && !yields && (!out_vld_q || view_o.ready) |=> !out_vld_q)
  `CFDZ_ASSERT(a_full_stage_blocks, s1_vld_q && !adv |-> !pt_i.ready)
  `CFDZ_ASSERT(a_moved_only_on_last, adv && yields && moved_d |-> s1_req_q == REQ_POINT && s1_last_q)
  `CFDZ_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_vld_q && !s1_vld_q)

endmodule
